/* hw/rtl/i2cram_pkg.sv */
// shared types and constants of the i2c register access master
package i2cram_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SHORT_DELAY = 2'd0,
        REG_LONG_DELAY  = 2'd1,
        REG_ACK_TRIES   = 2'd2
    } t_reg;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_START_A = 14'b00000000000010,
        PH_START_B = 14'b00000000000100,
        PH_START_C = 14'b00000000001000,
        PH_W_SETUP = 14'b00000000010000,
        PH_W_LOW   = 14'b00000000100000,
        PH_W_HIGH  = 14'b00000001000000,
        PH_ACK     = 14'b00000010000000,
        PH_R_LOW   = 14'b00000100000000,
        PH_R_HIGH  = 14'b00001000000000,
        PH_R_TAIL  = 14'b00010000000000,
        PH_R_ACK   = 14'b00100000000000,
        PH_STOP_A  = 14'b01000000000000,
        PH_STOP_B  = 14'b10000000000000
    } t_phase;

    typedef enum logic [3:0] {
        ST_ADDR  = 4'b0001,
        ST_SUB   = 4'b0010,
        ST_RADDR = 4'b0100,
        ST_DATA  = 4'b1000
    } t_stage;

    localparam logic [7:0] RST_SHORT_DELAY = 8'd5;
    localparam logic [7:0] RST_LONG_DELAY  = 8'd30;
    localparam logic [7:0] RST_ACK_TRIES   = 8'd20;
    localparam logic [7:0] READ_BIT        = 8'h01;

    typedef struct packed {
        logic [7:0] short_delay;
        logic [7:0] long_delay;
        logic [7:0] ack_tries;
    } t_cfg;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dev_addr;
        logic [7:0] sub_addr;
        logic [5:0] byte_count;
        logic [7:0] wr_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_res;

endpackage

/* hw/rtl/i2cram_if.sv */
// valid/ready channel interfaces for command items and pin results
interface i2cram_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] dev_addr;
    logic [7:0] sub_addr;
    logic [5:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;

    modport source (
        output valid, cmd, dev_addr, sub_addr, byte_count, wr_byte, sda_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, dev_addr, sub_addr, byte_count, wr_byte, sda_in,
        output ready
    );
endinterface

interface i2cram_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       busy_res;
    logic       done_res;
    logic       status;

    modport source (
        output valid, scl_level, sda_release, rd_valid, rd_data, busy_res, done_res,
               status,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_release, rd_valid, rd_data, busy_res, done_res,
               status,
        output ready
    );
endinterface

/* hw/rtl/i2cram_ram.sv */
// generic single write port ram with registered read
module i2cram_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/i2cram_seq.sv */
// pin sequencer: start, byte, acknowledge and stop timing plus write byte store
module i2cram_seq #(
    parameter int BUF_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cram_pkg::t_item  i_item,
    input  i2cram_pkg::t_cfg   i_cfg,
    output i2cram_pkg::t_res   o_res
);
    import i2cram_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);

    t_phase         r_phase, n_phase;
    t_stage         r_stage, n_stage;
    logic [7:0]     r_wait, n_wait;
    logic [3:0]     r_bit, n_bit;
    logic [7:0]     r_shift, n_shift;
    logic [5:0]     r_byte, n_byte;
    logic [FW-1:0]  r_fill, n_fill;
    logic [7:0]     r_ack, n_ack;
    logic [7:0]     r_addr, n_addr;
    logic [7:0]     r_sub, n_sub;
    logic [5:0]     r_count, n_count;
    logic           r_is_read, n_is_read;
    logic           r_failed, n_failed;
    logic           r_scl, n_scl;
    logic           r_sda, n_sda;
    logic           r_fetch_oob;

    logic           w_ram_we;
    logic [7:0]     w_ram_rdata;
    logic [5:0]     w_fetch_idx;
    logic [8:0]     w_fetch_ext;
    logic [7:0]     w_fetch_byte;
    logic [7:0]     w_short_n, w_long_n, w_tries_n;
    logic [8:0]     w_wait_inc, w_ack_inc;
    logic           w_short_hit, w_long_hit;
    logic [3:0]     w_bit_inc;
    logic [5:0]     w_byte_inc;
    logic [7:0]     w_rx_shift;
    t_res           w_res;

    // the byte the next acknowledge may need is read ahead through the registered store read
    assign w_fetch_idx  = (r_stage == ST_DATA) ? r_byte + 6'd1 : 6'd0;
    assign w_fetch_ext  = {3'b000, w_fetch_idx};
    assign w_fetch_byte = r_fetch_oob ? 8'h00 : w_ram_rdata;

    i2cram_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_item.wr_byte),
        .i_raddr (w_fetch_ext[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // zero register values act as one
    assign w_short_n   = (i_cfg.short_delay == 8'd0) ? 8'd1 : i_cfg.short_delay;
    assign w_long_n    = (i_cfg.long_delay == 8'd0) ? 8'd1 : i_cfg.long_delay;
    assign w_tries_n   = (i_cfg.ack_tries == 8'd0) ? 8'd1 : i_cfg.ack_tries;
    assign w_wait_inc  = {1'b0, r_wait} + 9'd1;
    assign w_ack_inc   = {1'b0, r_ack} + 9'd1;
    assign w_short_hit = w_wait_inc >= {1'b0, w_short_n};
    assign w_long_hit  = w_wait_inc >= {1'b0, w_long_n};
    assign w_bit_inc   = r_bit + 4'd1;
    assign w_byte_inc  = r_byte + 6'd1;
    assign w_rx_shift  = {r_shift[6:0], i_item.sda_in};

    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_wait    = r_wait;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_byte    = r_byte;
        n_fill    = r_fill;
        n_ack     = r_ack;
        n_addr    = r_addr;
        n_sub     = r_sub;
        n_count   = r_count;
        n_is_read = r_is_read;
        n_failed  = r_failed;
        n_scl     = r_scl;
        n_sda     = r_sda;
        w_ram_we  = 1'b0;
        w_res     = '0;

        if (i_step) begin
            unique case (i_item.cmd)
                CMD_PUSH: begin
                    if (r_phase == PH_IDLE && r_fill < FW'(BUF_DEPTH)) begin
                        w_ram_we = 1'b1;
                        n_fill   = r_fill + FW'(1);
                    end
                end
                CMD_READ, CMD_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_addr    = i_item.dev_addr;
                        n_sub     = i_item.sub_addr;
                        n_count   = i_item.byte_count;
                        n_is_read = (i_item.cmd == CMD_READ);
                        n_byte    = 6'd0;
                        n_bit     = 4'd0;
                        n_ack     = 8'd0;
                        n_stage   = ST_ADDR;
                        n_failed  = 1'b0;
                        n_scl     = 1'b1;
                        n_sda     = 1'b1;
                        n_wait    = 8'd0;
                        n_phase   = PH_START_A;
                    end
                end
                CMD_TICK: begin
                    unique case (r_phase)
                        PH_IDLE: begin
                        end
                        PH_START_A: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait  = 8'd0;
                                n_sda   = 1'b0;
                                n_phase = PH_START_B;
                            end
                        end
                        PH_START_B: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait  = 8'd0;
                                n_scl   = 1'b0;
                                n_phase = PH_START_C;
                            end
                        end
                        PH_START_C: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_shift = (r_stage == ST_RADDR) ? (r_addr | READ_BIT) : r_addr;
                                n_bit   = 4'd0;
                                n_wait  = 8'd0;
                                n_phase = PH_W_SETUP;
                            end
                        end
                        PH_W_SETUP: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_short_hit) begin
                                n_wait  = 8'd0;
                                n_sda   = r_shift[7];
                                n_phase = PH_W_LOW;
                            end
                        end
                        PH_W_LOW: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_short_hit) begin
                                n_wait  = 8'd0;
                                n_scl   = 1'b1;
                                n_phase = PH_W_HIGH;
                            end
                        end
                        PH_W_HIGH: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait  = 8'd0;
                                n_scl   = 1'b0;
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = w_bit_inc;
                                if (w_bit_inc >= 4'd8) begin
                                    // release sda and raise scl for the ack slot
                                    n_sda   = 1'b1;
                                    n_scl   = 1'b1;
                                    n_ack   = 8'd0;
                                    n_phase = PH_ACK;
                                end else begin
                                    n_phase = PH_W_SETUP;
                                end
                            end
                        end
                        PH_ACK: begin
                            if (!i_item.sda_in) begin
                                n_scl = 1'b0;
                                unique case (r_stage)
                                    ST_ADDR: begin
                                        n_stage = ST_SUB;
                                        n_shift = r_sub;
                                        n_bit   = 4'd0;
                                        n_wait  = 8'd0;
                                        n_phase = PH_W_SETUP;
                                    end
                                    ST_SUB: begin
                                        if (r_is_read) begin
                                            // repeated start
                                            n_scl   = 1'b1;
                                            n_sda   = 1'b1;
                                            n_stage = ST_RADDR;
                                            n_wait  = 8'd0;
                                            n_phase = PH_START_A;
                                        end else if (r_count != 6'd0) begin
                                            n_byte  = 6'd0;
                                            n_stage = ST_DATA;
                                            n_shift = w_fetch_byte;
                                            n_bit   = 4'd0;
                                            n_wait  = 8'd0;
                                            n_phase = PH_W_SETUP;
                                        end else begin
                                            n_sda   = 1'b0;
                                            n_wait  = 8'd0;
                                            n_phase = PH_STOP_A;
                                        end
                                    end
                                    ST_RADDR: begin
                                        n_byte = 6'd0;
                                        n_wait = 8'd0;
                                        if (r_count != 6'd0) begin
                                            n_sda   = 1'b1;
                                            n_bit   = 4'd0;
                                            n_shift = 8'd0;
                                            n_phase = PH_R_LOW;
                                        end else begin
                                            n_sda   = 1'b0;
                                            n_phase = PH_STOP_A;
                                        end
                                    end
                                    default: begin
                                        // data stage: next stored byte or stop
                                        n_byte = w_byte_inc;
                                        n_wait = 8'd0;
                                        if (w_byte_inc < r_count && w_byte_inc != 6'd0) begin
                                            n_shift = w_fetch_byte;
                                            n_bit   = 4'd0;
                                            n_phase = PH_W_SETUP;
                                        end else begin
                                            n_sda   = 1'b0;
                                            n_phase = PH_STOP_A;
                                        end
                                    end
                                endcase
                            end else begin
                                n_ack = w_ack_inc[7:0];
                                if (w_ack_inc >= {1'b0, w_tries_n}) begin
                                    n_scl    = 1'b0;
                                    n_failed = 1'b1;
                                    n_sda    = 1'b0;
                                    n_wait   = 8'd0;
                                    n_phase  = PH_STOP_A;
                                end
                            end
                        end
                        PH_R_LOW: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_short_hit) begin
                                n_wait  = 8'd0;
                                n_scl   = 1'b1;
                                n_phase = PH_R_HIGH;
                            end
                        end
                        PH_R_HIGH: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait  = 8'd0;
                                n_shift = w_rx_shift;
                                n_scl   = 1'b0;
                                n_bit   = w_bit_inc;
                                if (w_bit_inc == 4'd8) begin
                                    w_res.rd_valid = 1'b1;
                                    w_res.rd_data  = w_rx_shift;
                                end
                                n_phase = PH_R_TAIL;
                            end
                        end
                        PH_R_TAIL: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_short_hit) begin
                                n_wait = 8'd0;
                                if (r_bit < 4'd8) begin
                                    n_phase = PH_R_LOW;
                                end else begin
                                    // master ack on all but the last byte
                                    if ({1'b0, r_byte} + 7'd1 < {1'b0, r_count}) begin
                                        n_sda = 1'b0;
                                    end
                                    n_scl   = 1'b1;
                                    n_phase = PH_R_ACK;
                                end
                            end
                        end
                        PH_R_ACK: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait = 8'd0;
                                n_scl  = 1'b0;
                                n_byte = w_byte_inc;
                                if (w_byte_inc < r_count) begin
                                    n_sda   = 1'b1;
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                    n_phase = PH_R_LOW;
                                end else begin
                                    n_sda   = 1'b0;
                                    n_phase = PH_STOP_A;
                                end
                            end
                        end
                        PH_STOP_A: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait  = 8'd0;
                                n_scl   = 1'b1;
                                n_phase = PH_STOP_B;
                            end
                        end
                        PH_STOP_B: begin
                            n_wait = w_wait_inc[7:0];
                            if (w_long_hit) begin
                                n_wait          = 8'd0;
                                n_sda           = 1'b1;
                                n_phase         = PH_IDLE;
                                w_res.done_res  = 1'b1;
                                w_res.status    = r_failed;
                                if (!r_is_read) begin
                                    n_fill = '0;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_wait  = 8'd0;
                        end
                    endcase
                end
            endcase
        end

        w_res.scl_level   = n_scl;
        w_res.sda_release = n_sda;
        w_res.busy_res    = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_stage   <= ST_ADDR;
            r_wait    <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_byte    <= '0;
            r_fill    <= '0;
            r_ack     <= '0;
            r_addr    <= '0;
            r_sub     <= '0;
            r_count   <= '0;
            r_is_read <= 1'b0;
            r_failed  <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_wait    <= n_wait;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_byte    <= n_byte;
            r_fill    <= n_fill;
            r_ack     <= n_ack;
            r_addr    <= n_addr;
            r_sub     <= n_sub;
            r_count   <= n_count;
            r_is_read <= n_is_read;
            r_failed  <= n_failed;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    // read-ahead index beyond the store sends zero
    always_ff @(posedge i_clk) begin
        r_fetch_oob <= (w_fetch_ext >= 9'(BUF_DEPTH));
    end

    assign o_res = w_res;

endmodule

/* hw/rtl/i2c_register_access_master_top.sv */
// top level of the i2c register access master: config registers, sequencer, result register
// the result of an item is registered and presented in the cycle after the item is accepted
// throughput: one item per cycle, taken whenever the result register is empty or drained
//   in the same cycle, so items can follow back to back
// one tick item advances the pin sequencer by one timing step, settled within that cycle
// reset (synchronous, active low): idle, both pins released, store empty, registers 5/30/20
module i2c_register_access_master_top #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command items in, pin results out
    i2cram_in_if.sink   i_req,
    i2cram_out_if.source o_rsp,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cram_pkg::*;

    t_cfg  r_cfg;
    t_item w_item;
    t_res  w_res;
    t_res  r_res;
    logic  r_out_valid;
    logic  w_in_ready;
    logic  w_step;
    logic  w_cfg_wr;
    t_reg  w_reg_sel;

    // configuration registers, written in the access phase of an apb transaction
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_delay <= RST_SHORT_DELAY;
            r_cfg.long_delay  <= RST_LONG_DELAY;
            r_cfg.ack_tries   <= RST_ACK_TRIES;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                REG_SHORT_DELAY: r_cfg.short_delay <= pwdata[7:0];
                REG_LONG_DELAY:  r_cfg.long_delay  <= pwdata[7:0];
                REG_ACK_TRIES:   r_cfg.ack_tries   <= pwdata[7:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_SHORT_DELAY: prdata = {24'd0, r_cfg.short_delay};
            REG_LONG_DELAY:  prdata = {24'd0, r_cfg.long_delay};
            REG_ACK_TRIES:   prdata = {24'd0, r_cfg.ack_tries};
            default:         prdata = 32'd0;
        endcase
    end

    // input side: accept whenever the result register can take the new result
    assign w_in_ready  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_in_ready;
    assign w_step      = i_req.valid && w_in_ready;

    assign w_item.cmd        = t_cmd'(i_req.cmd);
    assign w_item.dev_addr   = i_req.dev_addr;
    assign w_item.sub_addr   = i_req.sub_addr;
    assign w_item.byte_count = i_req.byte_count;
    assign w_item.wr_byte    = i_req.wr_byte;
    assign w_item.sda_in     = i_req.sda_in;

    // state update and result for the accepted item, both formed in the cycle it is accepted
    i2cram_seq #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register: one result per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.scl_level   = r_res.scl_level;
    assign o_rsp.sda_release = r_res.sda_release;
    assign o_rsp.rd_valid    = r_res.rd_valid;
    assign o_rsp.rd_data     = r_res.rd_data;
    assign o_rsp.busy_res    = r_res.busy_res;
    assign o_rsp.done_res    = r_res.done_res;
    assign o_rsp.status      = r_res.status;

endmodule

/* bench/tb_i2c_register_access_master_top.sv */
// self-checking bench for the i2c register access master: pin sequencing, acks, reads, config
`timescale 1ns / 100ps

module tb_i2c_register_access_master_top;
    import i2cram_pkg::*;

    localparam int STORE_DEPTH = 64;

    // scoreboard: mirrors the pin sequencer and holds the pin levels still owed by the block
    class pin_scoreboard #(int DEPTH = 64);
        logic [7:0]  short_dly, long_dly, ack_lim;
        t_phase      ph;
        t_stage      stg;
        int unsigned wait_cnt, bit_idx, byte_idx, fill, ack_cnt, count, written_hi;
        logic [7:0]  shreg, addr, sub;
        logic [7:0]  store [DEPTH];
        bit          rd, failed, scl, sda;
        t_res        pins_due[$];
        int          effective, mismatches, checked, dones, nacks, bytes_in;

        function new();
            short_dly = RST_SHORT_DELAY;
            long_dly = RST_LONG_DELAY;
            ack_lim = RST_ACK_TRIES;
            ph = PH_IDLE;
            stg = ST_ADDR;
            wait_cnt = 0; bit_idx = 0; byte_idx = 0; fill = 0; ack_cnt = 0;
            count = 0; written_hi = 0;
            shreg = '0; addr = '0; sub = '0;
            rd = 0; failed = 0; scl = 1; sda = 1;
            effective = 0; mismatches = 0; checked = 0; dones = 0; nacks = 0; bytes_in = 0;
        endfunction

        function void set_reg(t_reg r, logic [7:0] v);
            case (r)
                REG_SHORT_DELAY: short_dly = v;
                REG_LONG_DELAY:  long_dly = v;
                REG_ACK_TRIES:   ack_lim = v;
                default: ;
            endcase
        endfunction

        function bit elapsed(logic [7:0] n);
            int unsigned lim;
            lim = (n == 8'd0) ? 1 : 32'(n);
            wait_cnt++;
            if (wait_cnt >= lim) begin
                wait_cnt = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [7:0] stored(int unsigned i);
            return (i < DEPTH) ? store[i] : 8'h00;
        endfunction

        function void load_byte(logic [7:0] v);
            shreg = v;
            bit_idx = 0;
            wait_cnt = 0;
            ph = PH_W_SETUP;
        endfunction

        function void go_stop();
            sda = 0;
            wait_cnt = 0;
            ph = PH_STOP_A;
        endfunction

        function void go_read_byte();
            sda = 1;
            bit_idx = 0;
            shreg = '0;
            wait_cnt = 0;
            ph = PH_R_LOW;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction

        // one accepted command: advance the sequencer and queue the pin levels it leaves
        function void note_command(t_item it);
            t_res r;
            r = '0;
            if (it.cmd == CMD_TICK)
                effective += int'(ph != PH_IDLE);
            else
                effective += int'(ph == PH_IDLE && !(it.cmd == CMD_PUSH && fill >= DEPTH));
            case (it.cmd)
                CMD_PUSH: begin
                    if (ph == PH_IDLE && fill < DEPTH) begin
                        store[fill] = it.wr_byte;
                        fill++;
                        if (fill > written_hi) written_hi = fill;
                    end
                end
                CMD_READ, CMD_WRITE: begin
                    if (ph == PH_IDLE) begin
                        addr = it.dev_addr;
                        sub = it.sub_addr;
                        count = 32'(it.byte_count);
                        rd = (it.cmd == CMD_READ);
                        byte_idx = 0; bit_idx = 0; ack_cnt = 0;
                        stg = ST_ADDR;
                        failed = 0;
                        scl = 1; sda = 1;
                        wait_cnt = 0;
                        ph = PH_START_A;
                    end
                end
                default: begin
                    case (ph)
                        PH_START_A: if (elapsed(long_dly)) begin
                            sda = 0;
                            ph = PH_START_B;
                        end
                        PH_START_B: if (elapsed(long_dly)) begin
                            scl = 0;
                            ph = PH_START_C;
                        end
                        PH_START_C: if (elapsed(long_dly))
                            load_byte((stg == ST_RADDR) ? (addr | READ_BIT) : addr);
                        PH_W_SETUP: if (elapsed(short_dly)) begin
                            sda = shreg[7];
                            ph = PH_W_LOW;
                        end
                        PH_W_LOW: if (elapsed(short_dly)) begin
                            scl = 1;
                            ph = PH_W_HIGH;
                        end
                        PH_W_HIGH: if (elapsed(long_dly)) begin
                            scl = 0;
                            shreg = shreg << 1;
                            bit_idx++;
                            if (bit_idx >= 8) begin
                                sda = 1;
                                scl = 1;
                                ack_cnt = 0;
                                ph = PH_ACK;
                            end else begin
                                ph = PH_W_SETUP;
                            end
                        end
                        PH_ACK: if (!it.sda_in) begin
                            scl = 0;
                            case (stg)
                                ST_ADDR: begin
                                    stg = ST_SUB;
                                    load_byte(sub);
                                end
                                ST_SUB: begin
                                    if (rd) begin
                                        scl = 1;
                                        sda = 1;
                                        stg = ST_RADDR;
                                        wait_cnt = 0;
                                        ph = PH_START_A;
                                    end else if (count > 0) begin
                                        byte_idx = 0;
                                        stg = ST_DATA;
                                        load_byte(stored(0));
                                    end else begin
                                        go_stop();
                                    end
                                end
                                ST_RADDR: begin
                                    byte_idx = 0;
                                    if (count > 0) go_read_byte();
                                    else go_stop();
                                end
                                default: begin
                                    byte_idx = (byte_idx + 1) & 63;
                                    if (byte_idx < count && byte_idx != 0)
                                        load_byte(stored(byte_idx));
                                    else
                                        go_stop();
                                end
                            endcase
                        end else begin
                            ack_cnt++;
                            if (ack_cnt >= ((ack_lim == 8'd0) ? 1 : 32'(ack_lim))) begin
                                scl = 0;
                                failed = 1;
                                go_stop();
                            end
                        end
                        PH_R_LOW: if (elapsed(short_dly)) begin
                            scl = 1;
                            ph = PH_R_HIGH;
                        end
                        PH_R_HIGH: if (elapsed(long_dly)) begin
                            shreg = {shreg[6:0], it.sda_in};
                            scl = 0;
                            bit_idx++;
                            if (bit_idx == 8) begin
                                r.rd_valid = 1'b1;
                                r.rd_data = shreg;
                                bytes_in++;
                            end
                            ph = PH_R_TAIL;
                        end
                        PH_R_TAIL: if (elapsed(short_dly)) begin
                            if (bit_idx < 8) begin
                                ph = PH_R_LOW;
                            end else begin
                                if (byte_idx + 1 < count) sda = 0;
                                scl = 1;
                                ph = PH_R_ACK;
                            end
                        end
                        PH_R_ACK: if (elapsed(long_dly)) begin
                            scl = 0;
                            byte_idx++;
                            if (byte_idx < count) go_read_byte();
                            else go_stop();
                        end
                        PH_STOP_A: if (elapsed(long_dly)) begin
                            scl = 1;
                            ph = PH_STOP_B;
                        end
                        PH_STOP_B: if (elapsed(long_dly)) begin
                            sda = 1;
                            ph = PH_IDLE;
                            r.done_res = 1'b1;
                            r.status = failed;
                            dones++;
                            nacks += int'(failed);
                            if (!rd) fill = 0;
                        end
                        default: ;
                    endcase
                end
            endcase
            r.scl_level = scl;
            r.sda_release = sda;
            r.busy_res = (ph != PH_IDLE);
            pins_due.push_back(r);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pins(t_res got);
            t_res want;
            if (pins_due.size() == 0) begin
                $error("result transaction with no command outstanding");
                mismatches++;
                return;
            end
            want = pins_due.pop_front();
            checked++;
            compare("scl_level", want.scl_level, got.scl_level);
            compare("sda_release", want.sda_release, got.sda_release);
            compare("rd_valid", want.rd_valid, got.rd_valid);
            compare("rd_data", want.rd_data, got.rd_data);
            compare("busy_res", want.busy_res, got.busy_res);
            compare("done_res", want.done_res, got.done_res);
            compare("status", want.status, got.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cram_in_if  req_if ();
    i2cram_out_if rsp_if ();

    pin_scoreboard #(STORE_DEPTH) sb;

    // knobs shared between the command driver and the result taker
    bit jitter_on = 1'b1;   // random idle cycles on both sides
    int rsp_hold  = 0;      // request for a long hold-off on the result side
    int noise_pct = 3;      // share of pushes and starts thrown in while a transfer runs
    int nack_pct  = 15;     // chance that an acknowledge slot gets no answer
    bit nack_this = 1'b0;
    int transfers = 0;
    int settings  = 1;

    i2c_register_access_master_top #(.BUF_DEPTH(STORE_DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // safety net against a hung handshake
    initial begin
        #5_000_000;
        $display("tb_i2c_register_access_master_top failed");
        $finish;
    end

    // the slave side of the bus: answers acknowledge slots and supplies read data
    function automatic logic bus_sda();
        case (sb.ph)
            PH_ACK: begin
                // decide once per slot, on its first sampled tick
                if (sb.ack_cnt == 0) nack_this = ($urandom_range(99) < nack_pct);
                if (nack_this) return 1'b1;
                // a late acknowledge, but never so late that the master gives up
                if (sb.ack_cnt + 1 < 32'(sb.ack_lim) && $urandom_range(99) < 40) return 1'b1;
                return 1'b0;
            end
            default: return 1'($urandom_range(1));
        endcase
    endfunction

    // offer one command transaction and wait until the block takes it
    task automatic send(input t_cmd c, input logic [7:0] da, input logic [7:0] sa,
                        input logic [5:0] n, input logic [7:0] wb, input logic s);
        t_item it;
        it = '{cmd: c, dev_addr: da, sub_addr: sa, byte_count: n, wr_byte: wb, sda_in: s};
        while (jitter_on && $urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= c;
        req_if.dev_addr   <= da;
        req_if.sub_addr   <= sa;
        req_if.byte_count <= n;
        req_if.wr_byte    <= wb;
        req_if.sda_in     <= s;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_command(it);
    endtask

    task automatic tick(input logic s);
        send(CMD_TICK, 8'($urandom), 8'($urandom), 6'($urandom), 8'($urandom), s);
    endtask

    task automatic push(input logic [7:0] b);
        send(CMD_PUSH, 8'($urandom), 8'($urandom), 6'($urandom), b, 1'($urandom));
    endtask

    // one whole bus transfer: optional pushes, the start, then ticks until stop,
    // with the odd ignored push or start slipped in while busy
    task automatic run_transfer(input bit is_rd, input int pushes, input int want,
                                input logic [7:0] da, input logic [7:0] sa);
        int n;
        repeat (pushes) push(8'($urandom));
        // a write never reaches a store entry that has not been filled yet
        n = is_rd ? want : ((want > int'(sb.written_hi)) ? int'(sb.written_hi) : want);
        send(is_rd ? CMD_READ : CMD_WRITE, da, sa, 6'(n), 8'($urandom), 1'($urandom));
        transfers++;
        while (sb.ph != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct)
                send(t_cmd'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                     6'($urandom), 8'($urandom), 1'($urandom));
            else
                tick(bus_sda());
        end
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input t_reg r, input logic [7:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
    endtask

    // apb read: setup cycle, then access cycle; the value is checked at its last edge
    task automatic read_reg(input t_reg r, input logic [7:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== {24'd0, want}) begin
            $error("%s: expected %0h, got %0h", r.name(), want, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // bit timing is only changed with the sequencer idle and nothing in flight
    task automatic set_timing(input logic [7:0] s, input logic [7:0] l, input logic [7:0] a);
        settle();
        write_reg(REG_SHORT_DELAY, s);
        write_reg(REG_LONG_DELAY, l);
        write_reg(REG_ACK_TRIES, a);
        settings++;
    endtask

    // mostly short transfers with random content, the odd idle tick or longer burst
    task automatic random_phase(input int budget);
        int base;
        base = sb.effective;
        while (sb.effective - base < budget) begin
            if ($urandom_range(9) == 0) tick(1'($urandom_range(1)));
            run_transfer(1'($urandom_range(1)), $urandom_range(0, 4),
                         ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3),
                         8'($urandom), 8'($urandom));
        end
    endtask

    // result side: take a transaction when offered, stall at random or on request
    initial begin
        t_res got;
        int   hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.scl_level   = rsp_if.scl_level;
                got.sda_release = rsp_if.sda_release;
                got.rd_valid    = rsp_if.rd_valid;
                got.rd_data     = rsp_if.rd_data;
                got.busy_res    = rsp_if.busy_res;
                got.done_res    = rsp_if.done_res;
                got.status      = rsp_if.status;
                sb.check_pins(got);
            end
            if (rsp_hold > 0) begin
                hold_left = rsp_hold;
                rsp_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(jitter_on && $urandom_range(99) < 17);
            end
        end
    end

    // stimulus: directed corners first, then random transfers over several timings
    initial begin
        sb = new();
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= CMD_TICK;
        req_if.dev_addr   <= '0;
        req_if.sub_addr   <= '0;
        req_if.byte_count <= '0;
        req_if.wr_byte    <= '0;
        req_if.sda_in     <= 1'b1;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register values after reset, then the top of their range read back
        read_reg(REG_SHORT_DELAY, RST_SHORT_DELAY);
        read_reg(REG_LONG_DELAY, RST_LONG_DELAY);
        read_reg(REG_ACK_TRIES, RST_ACK_TRIES);
        write_reg(REG_SHORT_DELAY, 8'd255);
        write_reg(REG_LONG_DELAY, 8'd255);
        write_reg(REG_ACK_TRIES, 8'd255);
        read_reg(REG_SHORT_DELAY, 8'd255);
        read_reg(REG_LONG_DELAY, 8'd255);
        read_reg(REG_ACK_TRIES, 8'd255);

        // ticks while idle change nothing
        tick(1'b0);
        tick(1'b1);

        // fastest timing, single-try acknowledge
        set_timing(8'd1, 8'd1, 8'd1);
        // fill the store to the brim; the extra push is dropped and the first entry survives
        repeat (STORE_DEPTH + 1) push(8'($urandom));
        run_transfer(1'b0, 0, 1, 8'h00, 8'hFF);
        // zero-length read: address with the read bit, then straight to stop
        run_transfer(1'b1, 0, 0, 8'hA4, 8'h5B);
        // no acknowledge at all on the address
        nack_pct = 100;
        run_transfer(1'b0, 1, 1, 8'h12, 8'h34);
        nack_pct = 15;

        set_timing(8'd2, 8'd1, 8'd4);
        random_phase(50);

        // a long stretch with no idle cycles on either side
        jitter_on = 1'b0;
        set_timing(8'd1, 8'd2, 8'd3);
        random_phase(50);

        // result side holds off for a while so the block backs up and stalls its input
        jitter_on = 1'b1;
        set_timing(8'd1, 8'd1, 8'd2);
        rsp_hold = 300;
        random_phase(50);

        settle();
        // room for a stray result after the last one owed
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) $error("%0d result transactions never arrived", sb.pending());
        $display("covered %0d commands (%0d acted on), %0d transfers, %0d stops, %0d no-ack",
                 sb.checked, sb.effective, transfers, sb.dones, sb.nacks);
        $display("%0d bytes received over %0d timing settings", sb.bytes_in, settings);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_i2c_register_access_master_top passed");
        else
            $display("tb_i2c_register_access_master_top failed");
        $finish;
    end

endmodule
